[design/apc_pkg.sv]
// Shared types and constants for the amicable pair checker.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package apc_pkg;

  // Width of the input values.
  localparam int VALUE_BITS = 24;
  // Width of a trial divisor: it runs up to isqrt(x) + 1.
  localparam int DIV_BITS   = (VALUE_BITS + 1) / 2 + 1;
  // Width of the running divisor sum.
  localparam int SUM_BITS   = VALUE_BITS + 3;
  // Width of the reported candidate.
  localparam int CAND_BITS  = 27;
  // Width that holds an exact candidate and any value it is compared with.
  localparam int EXT_BITS   = (SUM_BITS + 1 > CAND_BITS) ? SUM_BITS + 1 : CAND_BITS;
  // Width of the divider step counter.
  localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);

  localparam logic [CAND_BITS-1:0] CAND_MAX = {CAND_BITS{1'b1}};
  localparam logic [DIV_BITS-1:0]  FIRST_DIVISOR = DIV_BITS'(2);

  // Command codes.
  localparam logic CMD_PAIR     = 1'b0;
  localparam logic CMD_INTERVAL = 1'b1;

  // One request.
  typedef struct packed {
    logic                  cmd;
    logic [VALUE_BITS-1:0] first_value;
    logic [VALUE_BITS-1:0] second_value;
    logic [VALUE_BITS-1:0] low_bound;
    logic [VALUE_BITS-1:0] high_bound;
  } apc_req_t;

  // One result.
  typedef struct packed {
    logic                 verdict;
    logic [CAND_BITS-1:0] candidate_value;
  } apc_rsp_t;

  // Status of the shared divider.
  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [DIV_BITS-1:0]   remainder;
  } apc_div_rsp_t;

endpackage

`default_nettype wire

[design/amicable_pair_checker_top.sv]
// Top level of the amicable pair checker: command sequencing and result.
// Depends on apc_pkg and instantiates apc_divisor_sum.
//
// A request is taken when start is high and busy is low; busy then stays
// high until the result comes out, one request at a time. The result is on
// rsp for exactly one cycle, marked by done, and cannot be held off, so it
// must be captured in that cycle. The time per request is set by the single
// shared bit-serial divider, which runs one division for every trial
// divisor d = 2 .. isqrt(x) + 1 of an operand x. Command 0 runs this for
// both values, command 1 for the first one only, plus setup and result.
`default_nettype none

module amicable_pair_checker_top
  import apc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  apc_req_t  req,
  output logic      done,
  output apc_rsp_t  rsp
);

  typedef enum logic [1:0] {
    T_IDLE,
    T_SUM_A,
    T_SUM_B
  } state_t;

  state_t              state;
  apc_req_t            held;
  logic [EXT_BITS-1:0] first_cand;
  logic                sum_go;
  logic [VALUE_BITS-1:0] sum_value;
  logic                sum_finish;
  logic [SUM_BITS-1:0] sum_result;

  logic [EXT_BITS-1:0] cand_now;
  logic [EXT_BITS-1:0] a_ext;
  logic [EXT_BITS-1:0] b_ext;
  logic [EXT_BITS-1:0] lo_ext;
  logic [EXT_BITS-1:0] hi_ext;
  logic [CAND_BITS-1:0] cand_sat;

  apc_divisor_sum u_divisor_sum (
    .clk    (clk),
    .rst    (rst),
    .go     (sum_go),
    .value  (sum_value),
    .finish (sum_finish),
    .sum    (sum_result)
  );

  // Candidate of the operand just finished, and operands widened to match.
  always_comb begin
    cand_now = EXT_BITS'(sum_result) + EXT_BITS'(1);
    a_ext    = EXT_BITS'(held.first_value);
    b_ext    = EXT_BITS'(held.second_value);
    lo_ext   = EXT_BITS'(held.low_bound);
    hi_ext   = EXT_BITS'(held.high_bound);
    cand_sat = (first_cand > EXT_BITS'(CAND_MAX)) ? CAND_MAX
                                                  : first_cand[CAND_BITS-1:0];
  end

  // Command sequencer and registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= T_IDLE;
      sum_go <= 1'b0;
      done   <= 1'b0;
    end else begin
      sum_go <= 1'b0;
      done   <= 1'b0;
      case (state)
        T_IDLE: begin
          if (start) begin
            held      <= req;
            sum_value <= req.first_value;
            sum_go    <= 1'b1;
            state     <= T_SUM_A;
          end
        end
        T_SUM_A: begin
          if (sum_finish) begin
            first_cand <= cand_now;
            if (held.cmd == CMD_PAIR) begin
              sum_value <= held.second_value;
              sum_go    <= 1'b1;
              state     <= T_SUM_B;
            end else begin
              rsp.verdict         <= (cand_now >= lo_ext) && (cand_now <= hi_ext);
              rsp.candidate_value <= (cand_now > EXT_BITS'(CAND_MAX)) ? CAND_MAX
                                     : cand_now[CAND_BITS-1:0];
              done                <= 1'b1;
              state               <= T_IDLE;
            end
          end
        end
        T_SUM_B: begin
          if (sum_finish) begin
            rsp.verdict         <= (first_cand == b_ext) && (cand_now == a_ext);
            rsp.candidate_value <= cand_sat;
            done                <= 1'b1;
            state               <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != T_IDLE);

endmodule

`default_nettype wire

[design/apc_divider.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on apc_pkg for widths and the result struct.
`default_nettype none

module apc_divider
  import apc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] dividend,
  input  wire logic [DIV_BITS-1:0]   divisor,
  output apc_div_rsp_t               status
);

  logic                  running;
  logic [CNT_BITS-1:0]   count;
  logic [VALUE_BITS-1:0] quot;
  logic [DIV_BITS-1:0]   rem;
  logic [DIV_BITS-1:0]   dsr;
  logic                  done;

  logic [DIV_BITS:0]     trial;
  logic [DIV_BITS:0]     diff;
  logic                  fits;

  // Bring down the next dividend bit and try the subtraction.
  always_comb begin
    trial = {rem, quot[VALUE_BITS-1]};
    diff  = trial - {1'b0, dsr};
    fits  = (trial >= {1'b0, dsr});
  end

  // Step sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      count   <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= CNT_BITS'(VALUE_BITS);
        quot    <= dividend;
        rem     <= '0;
        dsr     <= divisor;
      end else if (running) begin
        quot  <= {quot[VALUE_BITS-2:0], fits};
        rem   <= fits ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
        count <= count - CNT_BITS'(1);
        if (count == CNT_BITS'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign status.done      = done;
  assign status.quotient  = quot;
  assign status.remainder = rem;

endmodule

`default_nettype wire

[design/apc_divisor_sum.sv]
// Trial division sequencer that forms the sum of the inner divisors of x.
// Depends on apc_pkg and drives one apc_divider.
`default_nettype none

module apc_divisor_sum
  import apc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  go,
  input  wire logic [VALUE_BITS-1:0] value,
  output logic                       finish,
  output logic [SUM_BITS-1:0]        sum
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_WAIT
  } state_t;

  state_t                state;
  logic [VALUE_BITS-1:0] x;
  logic [DIV_BITS-1:0]   trial_divisor;
  logic                  div_start;
  apc_div_rsp_t          div_status;

  logic                  past_root;
  logic [SUM_BITS-1:0]   add_q;
  logic [SUM_BITS-1:0]   sum_next;

  apc_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (x),
    .divisor  (trial_divisor),
    .status   (div_status)
  );

  // A quotient below the divisor means d * d > x, so the search is over.
  // A zero remainder adds d and its cofactor, the cofactor only if distinct.
  always_comb begin
    past_root = (div_status.quotient < VALUE_BITS'(trial_divisor));
    add_q     = (div_status.quotient != VALUE_BITS'(trial_divisor))
                ? SUM_BITS'(div_status.quotient) : '0;
    sum_next  = sum;
    if (div_status.remainder == '0) begin
      sum_next = sum + SUM_BITS'(trial_divisor) + add_q;
    end
  end

  // Sequencer: one division per trial divisor.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      finish        <= 1'b0;
      div_start     <= 1'b0;
      sum           <= '0;
      trial_divisor <= '0;
    end else begin
      finish    <= 1'b0;
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (go) begin
            x             <= value;
            trial_divisor <= FIRST_DIVISOR;
            sum           <= '0;
            div_start     <= 1'b1;
            state         <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (div_status.done) begin
            if (past_root) begin
              finish <= 1'b1;
              state  <= S_IDLE;
            end else begin
              sum           <= sum_next;
              trial_divisor <= trial_divisor + DIV_BITS'(1);
              div_start     <= 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/apc_checker.sv]
// Port-level checks for the amicable pair checker, bound to its top level.
// Depends on apc_pkg for the request and result structs.
`default_nettype none

module apc_checker
  import apc_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input apc_req_t  req,
  input wire logic done,
  input apc_rsp_t  rsp
);

  // An accepted request makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted request");

  // A result appears only once the block has gone idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // Leaving busy always comes with the result strobe.
  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("request finished without a result");

  // Each result is a single-cycle strobe.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // The candidate is at least one.
  a_cand_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.candidate_value != '0))
    else $error("candidate value of zero");

endmodule

bind amicable_pair_checker_top apc_checker u_apc_checker (.*);

`default_nettype wire

[verif/apc_result_checker.sv]
// Result checker for the amicable pair checker: watches the request and result channels.
// It predicts every result from the accepted request and compares field by field.
// Depends on apc_pkg for the request and result types.
`timescale 1ns / 100ps

module apc_result_checker
  import apc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic busy,
  input  apc_req_t  req,
  input  wire logic done,
  input  apc_rsp_t  rsp,
  output int        fail_count,
  output int        pending_results
);

  apc_rsp_t expected_results[$];
  apc_rsp_t oldest;
  int       errors_seen = 0;

  // Sum of the divisors d of x with 1 < d < x; a square root divisor counts once.
  // Values below 4 have no such divisor.
  function automatic longint unsigned inner_divisor_sum(input longint unsigned x);
    longint unsigned total;
    longint unsigned d;
    total = 0;
    if (x < 4) begin
      return 0;
    end
    for (d = 2; d * d <= x; d++) begin
      if (x % d == 0) begin
        total += d;
        if (x / d != d) begin
          total += x / d;
        end
      end
    end
    return total;
  endfunction

  // Expected result of one request. The comparisons use the exact candidate;
  // only the reported candidate saturates.
  function automatic apc_rsp_t amicable_verdict(input apc_req_t r);
    longint unsigned cand_first;
    longint unsigned cand_second;
    apc_rsp_t        res;
    cand_first = inner_divisor_sum(longint'(r.first_value)) + 1;
    if (r.cmd == CMD_PAIR) begin
      cand_second = inner_divisor_sum(longint'(r.second_value)) + 1;
      res.verdict = (cand_first == longint'(r.second_value)) &&
                    (cand_second == longint'(r.first_value));
    end else begin
      res.verdict = (cand_first >= longint'(r.low_bound)) &&
                    (cand_first <= longint'(r.high_bound));
    end
    res.candidate_value = (cand_first > longint'(CAND_MAX)) ? CAND_MAX
                                                             : CAND_BITS'(cand_first);
    return res;
  endfunction

  // Compare the result of this cycle first, then queue the prediction for a new request.
  always @(posedge clk) begin
    if (rst) begin
      expected_results.delete();
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: verdict %0d, candidate_value %0d",
                 rsp.verdict, rsp.candidate_value);
          errors_seen++;
        end else begin
          oldest = expected_results.pop_front();
          if (rsp.verdict !== oldest.verdict) begin
            $error("verdict mismatch: expected %0d, actual %0d", oldest.verdict,
                   rsp.verdict);
            errors_seen++;
          end
          if (rsp.candidate_value !== oldest.candidate_value) begin
            $error("candidate_value mismatch: expected %0d, actual %0d",
                   oldest.candidate_value, rsp.candidate_value);
            errors_seen++;
          end
        end
      end
      if (start && !busy) begin
        expected_results.push_back(amicable_verdict(req));
      end
    end
    fail_count <= errors_seen;
    pending_results <= expected_results.size();
  end

endmodule

[verif/tb_amicable_pair_checker_top.sv]
// Testbench top for the amicable pair checker: clock, reset, request stimulus and verdict.
// Depends on apc_pkg, amicable_pair_checker_top and apc_result_checker.
`timescale 1ns / 100ps

module tb_amicable_pair_checker_top;
  import apc_pkg::*;

  localparam int unsigned VALUE_MAX = (1 << VALUE_BITS) - 1;
  // The watchdog limit allows several times the longest pair check at the largest values.
  localparam int WATCHDOG_LIMIT = 1_000_000;
  localparam int RANDOM_REQUESTS = 78;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  apc_req_t req = '0;
  logic     done;
  apc_rsp_t rsp;
  int       fail_count;
  int       pending_results;
  int       stall_cycles = 0;
  bit       quiet_stretch = 1'b0;

  int unsigned pair_small[10];
  int unsigned pair_large[10];
  int unsigned perfect_numbers[4];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  amicable_pair_checker_top dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  apc_result_checker result_checker (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .req             (req),
    .done            (done),
    .rsp             (rsp),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // Watchdog: end the run when neither a request nor a result moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic apc_req_t make_request(input logic cmd, input int unsigned a,
                                            input int unsigned b, input int unsigned lo,
                                            input int unsigned hi);
    apc_req_t r;
    r.cmd          = cmd;
    r.first_value  = VALUE_BITS'(a);
    r.second_value = VALUE_BITS'(b);
    r.low_bound    = VALUE_BITS'(lo);
    r.high_bound   = VALUE_BITS'(hi);
    return r;
  endfunction

  // Mostly small values, since the run time grows with the square root of each operand.
  function automatic int unsigned random_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) begin
      return $urandom_range(1, 1023);
    end else if (roll < 99) begin
      return $urandom_range(1, 65535);
    end
    return $urandom_range(1, VALUE_MAX);
  endfunction

  // Offer one request and hold it until the block takes it. Optionally wait first
  // until every outstanding result has come back.
  task automatic issue_request(input apc_req_t r, input bit drain_first);
    int gap;
    if (quiet_stretch) begin
      gap = 0;
    end else begin
      gap = $urandom_range(0, 15);
    end
    if (gap > 0 || drain_first) begin
      start <= 1'b0;
    end
    if (drain_first) begin
      @(posedge clk);
      while (pending_results != 0) begin
        @(posedge clk);
      end
    end
    repeat (gap) @(posedge clk);
    start <= 1'b1;
    req   <= r;
    do begin
      @(posedge clk);
    end while (busy);
  endtask

  initial begin
    apc_req_t    r;
    int          i;
    int          kind;
    int          pick;
    int unsigned a;
    int unsigned b;
    int unsigned lo;
    int unsigned hi;

    pair_small      = '{220, 1184, 2620, 5020, 6232, 10744, 12285, 17296, 63020, 66928};
    pair_large      = '{284, 1210, 2924, 5564, 6368, 10856, 14595, 18416, 76084, 66992};
    perfect_numbers = '{6, 28, 496, 8128};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed requests: known pairs both ways, a perfect number, small values,
    // square roots, empty interval and the field extremes.
    issue_request(make_request(CMD_PAIR, 220, 284, 0, 0), 1'b0);
    issue_request(make_request(CMD_PAIR, 284, 220, 0, 0), 1'b0);
    issue_request(make_request(CMD_PAIR, 6, 6, 0, 0), 1'b0);
    issue_request(make_request(CMD_PAIR, 1, 1, 0, 0), 1'b0);
    issue_request(make_request(CMD_PAIR, 2, 3, 0, 0), 1'b0);
    issue_request(make_request(CMD_PAIR, 3, 1, 0, 0), 1'b0);
    issue_request(make_request(CMD_PAIR, 4, 3, 0, 0), 1'b0);
    issue_request(make_request(CMD_PAIR, 4, 4, 0, 0), 1'b0);
    issue_request(make_request(CMD_PAIR, 220, 285, 0, 0), 1'b0);
    issue_request(make_request(CMD_PAIR, 1184, 1210, 0, 0), 1'b0);
    issue_request(make_request(CMD_PAIR, 12285, 14595, 0, 0), 1'b0);
    issue_request(make_request(CMD_INTERVAL, 220, 1, 284, 284), 1'b0);
    issue_request(make_request(CMD_INTERVAL, 220, 1, 285, 300), 1'b0);
    issue_request(make_request(CMD_INTERVAL, 220, 1, 1, 283), 1'b0);
    issue_request(make_request(CMD_INTERVAL, 220, 1, 300, 200), 1'b0);
    issue_request(make_request(CMD_INTERVAL, 1, 1, 1, 1), 1'b0);
    issue_request(make_request(CMD_INTERVAL, 3, 7, 2, VALUE_MAX), 1'b0);
    issue_request(make_request(CMD_INTERVAL, 16, 1, 15, 15), 1'b0);
    issue_request(make_request(CMD_INTERVAL, 49, 1, 8, 8), 1'b0);
    issue_request(make_request(CMD_INTERVAL, 5, VALUE_MAX, VALUE_MAX, VALUE_MAX), 1'b0);
    issue_request(make_request(CMD_INTERVAL, VALUE_MAX, VALUE_MAX, 1, VALUE_MAX), 1'b0);
    issue_request(make_request(CMD_PAIR, 7, VALUE_MAX, 0, 0), 1'b0);

    // Random requests. The first one waits until the directed results are all back.
    for (i = 0; i < RANDOM_REQUESTS; i++) begin
      if ($urandom_range(0, 14) == 0) begin
        quiet_stretch = !quiet_stretch;
      end
      kind = $urandom_range(0, 99);
      pick = $urandom_range(0, 9);
      if (kind < 30) begin
        // True pairs in either order, or a perfect number checked against itself.
        if ($urandom_range(0, 4) == 0) begin
          a = perfect_numbers[$urandom_range(0, 3)];
          b = a;
        end else if ($urandom_range(0, 1) == 0) begin
          a = pair_small[pick];
          b = pair_large[pick];
        end else begin
          a = pair_large[pick];
          b = pair_small[pick];
        end
        r = make_request(CMD_PAIR, a, b, random_value(), random_value());
      end else if (kind < 45) begin
        // Near misses: a partner that is off by a little or belongs to another pair.
        a = pair_small[pick];
        if ($urandom_range(0, 1) == 0) begin
          b = pair_large[pick] + $urandom_range(1, 3);
        end else begin
          b = pair_large[(pick + $urandom_range(1, 9)) % 10];
        end
        r = make_request(CMD_PAIR, a, b, random_value(), random_value());
      end else if (kind < 70) begin
        // Interval around the order of the first value; sometimes empty.
        a  = random_value();
        lo = $urandom_range(1, a);
        hi = lo + $urandom_range(0, a);
        if ($urandom_range(0, 7) == 0) begin
          r = make_request(CMD_INTERVAL, a, $urandom_range(1, VALUE_MAX), hi + 1, lo);
        end else begin
          r = make_request(CMD_INTERVAL, a, $urandom_range(1, VALUE_MAX), lo, hi);
        end
      end else begin
        // Unstructured requests over the whole field ranges.
        r = make_request(($urandom_range(0, 1) == 0) ? CMD_PAIR : CMD_INTERVAL,
                         random_value(), random_value(),
                         $urandom_range(1, VALUE_MAX), $urandom_range(1, VALUE_MAX));
      end
      issue_request(r, (i == 0) || ($urandom_range(0, 19) == 0));
    end
    start <= 1'b0;

    // Let the last results come back, then a short tail for stray results.
    @(posedge clk);
    while (pending_results != 0) begin
      @(posedge clk);
    end
    repeat (50) @(posedge clk);

    if (fail_count == 0 && pending_results == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
design/apc_pkg.sv
design/apc_divider.sv
design/apc_divisor_sum.sv
design/amicable_pair_checker_top.sv
design/apc_checker.sv
verif/apc_result_checker.sv
verif/tb_amicable_pair_checker_top.sv
